@@ design/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the unpacker checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held
`define PRU_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pru assertion failed");

// Next-cycle implication, off while reset is held
`define PRU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pru assertion failed");

// Next-cycle implication, checked through reset as well
`define PRU_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("pru assertion failed");

`endif

@@ design/pru_pkg.sv @@
// ---------------------------------------------------------------------------
// pru_pkg
// Types, widths and packing tables for the packed raw pixel unpacker.
// ---------------------------------------------------------------------------
package pru_pkg;

  localparam int BYTE_W     = 8;
  localparam int PIX_W      = 14;
  localparam int FRAME_W    = 29;
  localparam int PHASE_W    = 3;
  localparam int RES_W      = 14;
  localparam int HELD_W     = 4;
  localparam int ACC_W      = 20;
  localparam int REST_W     = 3;
  localparam int DBITS_W    = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 29;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam int MAX_SIDE = 16384;
  localparam logic [FRAME_W-1:0] FRAME_CAP = FRAME_W'(MAX_SIDE * MAX_SIDE);
  localparam logic [FRAME_W-1:0] FRAME_RESET = FRAME_W'(1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_DEPTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_PIXELS = 1'b1;

  // Packing modes
  typedef enum logic [1:0] {
    MODE_RAW8  = 2'd0,
    MODE_RAW10 = 2'd1,
    MODE_RAW12 = 2'd2,
    MODE_RAW14 = 2'd3
  } depth_mode_t;

  // Settings seen by the front end
  typedef struct packed {
    depth_mode_t          mode;
    logic [FRAME_W-1:0]   limit;
  } pru_cfg_t;

  // Classified pixel: accumulated bits, number of bits below the sample, last flag
  typedef struct packed {
    logic [ACC_W-1:0]  acc;
    logic [REST_W-1:0] rest;
    logic              last;
  } pru_raw_t;

  function automatic logic [DBITS_W-1:0] depth_bits(depth_mode_t mode);
    logic [DBITS_W-1:0] d;
    unique case (mode)
      MODE_RAW8:  d = DBITS_W'(8);
      MODE_RAW10: d = DBITS_W'(10);
      MODE_RAW12: d = DBITS_W'(12);
      MODE_RAW14: d = DBITS_W'(14);
      default:    d = DBITS_W'(8);
    endcase
    return d;
  endfunction

  function automatic logic [PHASE_W-1:0] group_bytes(depth_mode_t mode);
    logic [PHASE_W-1:0] g;
    unique case (mode)
      MODE_RAW8:  g = PHASE_W'(1);
      MODE_RAW10: g = PHASE_W'(5);
      MODE_RAW12: g = PHASE_W'(3);
      MODE_RAW14: g = PHASE_W'(7);
      default:    g = PHASE_W'(1);
    endcase
    return g;
  endfunction

  // Leftover bits held at the start of a byte: (phase * 8) mod depth
  function automatic logic [HELD_W-1:0] held_bits(depth_mode_t mode,
                                                  logic [PHASE_W-1:0] phase);
    logic [HELD_W-1:0] h;
    h = '0;
    unique case (mode)
      MODE_RAW10: begin
        unique case (phase)
          3'd1:    h = HELD_W'(8);
          3'd2:    h = HELD_W'(6);
          3'd3:    h = HELD_W'(4);
          3'd4:    h = HELD_W'(2);
          default: h = '0;
        endcase
      end
      MODE_RAW12: begin
        unique case (phase)
          3'd1:    h = HELD_W'(8);
          3'd2:    h = HELD_W'(4);
          default: h = '0;
        endcase
      end
      MODE_RAW14: begin
        unique case (phase)
          3'd1:    h = HELD_W'(8);
          3'd2:    h = HELD_W'(2);
          3'd3:    h = HELD_W'(10);
          3'd4:    h = HELD_W'(4);
          3'd5:    h = HELD_W'(12);
          3'd6:    h = HELD_W'(6);
          default: h = '0;
        endcase
      end
      default: h = '0;
    endcase
    return h;
  endfunction

  // Frame pixel count, capped, rounded down to whole groups
  function automatic logic [FRAME_W-1:0] frame_limit(depth_mode_t mode,
                                                    logic [FRAME_W-1:0] fp);
    logic [FRAME_W-1:0] px;
    logic [FRAME_W-1:0] lim;
    px = (fp > FRAME_CAP) ? FRAME_CAP : fp;
    unique case (mode)
      MODE_RAW8:  lim = px;
      MODE_RAW12: lim = {px[FRAME_W-1:1], 1'b0};
      default:    lim = {px[FRAME_W-1:2], 2'b00};
    endcase
    return lim;
  endfunction

endpackage

@@ design/pru_stream_if.sv @@
// ---------------------------------------------------------------------------
// pru_stream_if
// Valid/ready channels for strip bytes in and pixel samples out.
// ---------------------------------------------------------------------------
interface pru_in_if;
  import pru_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              first_byte;

  modport source (output valid, data_byte, first_byte, input ready);
  modport sink   (input valid, data_byte, first_byte, output ready);
endinterface

interface pru_out_if;
  import pru_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;
  logic             last_pixel;

  modport source (output valid, pixel_value, last_pixel, input ready);
  modport sink   (input valid, pixel_value, last_pixel, output ready);
endinterface

@@ design/pru_front.sv @@
// ---------------------------------------------------------------------------
// pru_front
// Take strip bytes, track group phase, residue and pixel count, and
// classify each byte as holding a finished sample or not.
// ---------------------------------------------------------------------------
module pru_front (
  input  logic              clk,
  input  logic              rst_n,
  input  pru_pkg::pru_cfg_t cfg,
  pru_in_if.sink            in_bus,
  input  logic              q_full,
  output logic              push,
  output pru_pkg::pru_raw_t raw
);
  import pru_pkg::*;

  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [RES_W-1:0]   res_r, res_nxt;
  logic [FRAME_W-1:0] done_r, done_nxt;

  logic               accept;
  logic [PHASE_W-1:0] ph_in, ph_use, gbytes;
  logic [RES_W-1:0]   res_in, res_use, held_mask;
  logic [FRAME_W-1:0] done_in;
  logic [HELD_W-1:0]  held;
  logic [ACC_W-1:0]   acc, rest_mask;
  logic [DBITS_W-1:0] total, dbits;
  logic [REST_W-1:0]  rest;
  logic               past_frame, emit;
  logic [PHASE_W:0]   ph_inc;

  assign in_bus.ready = !q_full;
  assign accept       = in_bus.valid && in_bus.ready;

  // Classify the byte and work out the next state
  always_comb begin
    ph_in   = in_bus.first_byte ? '0 : phase_r;
    res_in  = in_bus.first_byte ? '0 : res_r;
    done_in = in_bus.first_byte ? '0 : done_r;

    gbytes     = group_bytes(cfg.mode);
    dbits      = depth_bits(cfg.mode);
    past_frame = (done_in >= cfg.limit);

    // Restart the group when the phase does not fit the mode
    ph_use  = (ph_in >= gbytes) ? '0 : ph_in;
    res_use = (ph_in >= gbytes) ? '0 : res_in;

    held      = held_bits(cfg.mode, ph_use);
    held_mask = (RES_W'(1) << held) - RES_W'(1);
    acc       = (ACC_W'(res_use & held_mask) << BYTE_W) | ACC_W'(in_bus.data_byte);
    total     = DBITS_W'(held) + DBITS_W'(BYTE_W);
    emit      = !past_frame && (total >= dbits);
    rest      = REST_W'(total - dbits);
    rest_mask = (ACC_W'(1) << rest) - ACC_W'(1);

    ph_inc = {1'b0, ph_use} + 1'b1;

    phase_nxt = ph_in;
    res_nxt   = res_in;
    done_nxt  = done_in;
    if (!past_frame) begin
      phase_nxt = (ph_inc >= {1'b0, gbytes}) ? '0 : ph_inc[PHASE_W-1:0];
      if (emit) begin
        res_nxt  = RES_W'(acc & rest_mask);
        done_nxt = done_in + 1'b1;
      end else begin
        res_nxt  = acc[RES_W-1:0];
      end
    end

    raw.acc  = acc;
    raw.rest = rest;
    raw.last = (done_in == cfg.limit - 1'b1);
  end

  assign push = accept && emit;

  // Hold strip state between bytes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      res_r   <= '0;
      done_r  <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      res_r   <= res_nxt;
      done_r  <= done_nxt;
    end
  end

endmodule

@@ design/pru_queue.sv @@
// ---------------------------------------------------------------------------
// pru_queue
// Short FIFO of classified pixels between front and back ends.
// ---------------------------------------------------------------------------
module pru_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  pru_pkg::pru_raw_t din,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output pru_pkg::pru_raw_t dout
);
  import pru_pkg::*;

  pru_raw_t           mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r, count_nxt;
  logic               do_push, do_pop;

  assign full      = (count_r == Q_CNT_W'(Q_DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign dout      = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

@@ design/pru_back.sv @@
// ---------------------------------------------------------------------------
// pru_back
// Extract each sample from its accumulated bits and hold it in the
// output register until taken.
// ---------------------------------------------------------------------------
module pru_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  pru_pkg::pru_raw_t q_data,
  output logic              q_pop,
  pru_out_if.source         out_bus
);
  import pru_pkg::*;

  logic             valid_r;
  logic [PIX_W-1:0] pixel_r;
  logic             last_r;

  assign q_pop = q_valid && (!valid_r || out_bus.ready);

  // Control: output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      valid_r <= 1'b0;
    end
  end

  // Payload: drop the bits below the sample
  always_ff @(posedge clk) begin
    if (q_pop) begin
      pixel_r <= PIX_W'(q_data.acc >> q_data.rest);
      last_r  <= q_data.last;
    end
  end

  assign out_bus.valid       = valid_r;
  assign out_bus.pixel_value = pixel_r;
  assign out_bus.last_pixel  = last_r;

endmodule

@@ design/packed_raw_pixel_unpacker.sv @@
// ---------------------------------------------------------------------------
// packed_raw_pixel_unpacker
// Unpack MSB-first packed raw8/10/12/14 strips into pixel samples.
// ---------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  in_bus   in   valid/ready   data_byte[7:0], first_byte
//  out_bus  out  valid/ready   pixel_value[13:0], last_pixel
//  cfg_*    in   cfg_we only   cfg_index[0], cfg_wdata[28:0]
//
//  One byte is taken per cycle while in_bus.ready is high; the sample that a
//  byte completes is written into the queue, then into the output register.
//  A four-entry queue decouples the two ends; in_bus.ready drops only when
//  it is full while out_bus stalls. Synchronous reset clears the control
//  state but not the stored data, and sets 8-bit mode with a one-pixel frame.
// ---------------------------------------------------------------------------
module packed_raw_pixel_unpacker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [pru_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pru_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  pru_in_if.sink                             in_bus,
  pru_out_if.source                          out_bus
);
  import pru_pkg::*;

  depth_mode_t        mode_r;
  logic [FRAME_W-1:0] frame_r;
  pru_cfg_t           cfg;

  logic     push, q_full, q_valid, q_pop;
  pru_raw_t raw_in, raw_out;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_RAW8;
      frame_r <= FRAME_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SAMPLE_DEPTH: mode_r  <= depth_mode_t'(cfg_wdata[1:0]);
        REG_FRAME_PIXELS: frame_r <= cfg_wdata[FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.mode  = mode_r;
  assign cfg.limit = frame_limit(mode_r, frame_r);

  pru_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_bus (in_bus),
    .q_full (q_full),
    .push   (push),
    .raw    (raw_in)
  );

  pru_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .din       (raw_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .dout      (raw_out)
  );

  pru_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_data  (raw_out),
    .q_pop   (q_pop),
    .out_bus (out_bus)
  );

endmodule

@@ design/pru_checker.sv @@
// ---------------------------------------------------------------------------
// pru_checker
// Port-level checks for the unpacker, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pru_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           cfg_we,
  input logic [pru_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [pru_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [pru_pkg::PIX_W-1:0]      pixel_value,
  input logic                           last_pixel
);
  import pru_pkg::*;

  depth_mode_t    mode_r;
  logic [PIX_W:0] out_word;
  logic           depth_ok;

  // Track the sample depth written through the config port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RAW8;
    end else if (cfg_we && (cfg_index == REG_SAMPLE_DEPTH)) begin
      mode_r <= depth_mode_t'(cfg_wdata[1:0]);
    end
  end

  assign out_word = {last_pixel, pixel_value};

  // Check the bits above the configured depth are clear
  always_comb begin
    unique case (mode_r)
      MODE_RAW8:  depth_ok = (pixel_value[13:8] == 6'h00);
      MODE_RAW10: depth_ok = (pixel_value[13:10] == 4'h0);
      MODE_RAW12: depth_ok = (pixel_value[13:12] == 2'b00);
      MODE_RAW14: depth_ok = 1'b1;
      default:    depth_ok = 1'b1;
    endcase
  end

  // A stalled sample holds
  `PRU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_word))

  // Samples never carry bits above the configured depth
  `PRU_ASSERT_SAME(a_depth_range, clk, rst_n, out_valid, depth_ok)

  // Reset leaves the output empty and the input open
  `PRU_ASSERT_NEXT_ALWAYS(a_reset_state, clk, !rst_n, !out_valid && in_ready)

endmodule

bind packed_raw_pixel_unpacker pru_checker u_pru_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .cfg_we      (cfg_we),
  .cfg_index   (cfg_index),
  .cfg_wdata   (cfg_wdata),
  .in_ready    (in_bus.ready),
  .out_valid   (out_bus.valid),
  .out_ready   (out_bus.ready),
  .pixel_value (out_bus.pixel_value),
  .last_pixel  (out_bus.last_pixel)
);
